### hw/rtl/fcch_pkg.sv
package fcch_pkg;

  localparam logic [7:0]  MAGIC0    = 8'h52;
  localparam logic [7:0]  MAGIC1    = 8'h53;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [31:0] HASH_K1   = 32'h9E3779B9;
  localparam logic [31:0] HASH_K2   = 32'h7FEB352D;

  localparam logic [7:0] POS_MAGIC0     = 8'd0;
  localparam logic [7:0] POS_MAGIC1     = 8'd1;
  localparam logic [7:0] POS_VERSION    = 8'd2;
  localparam logic [7:0] POS_CHANNEL    = 8'd9;
  localparam logic [7:0] POS_SEQ_FIRST  = 8'd10;
  localparam logic [7:0] POS_SEQ_LAST   = 8'd13;
  localparam logic [7:0] POS_SESS_FIRST = 8'd14;
  localparam logic [7:0] POS_SESS_LAST  = 8'd17;
  localparam logic [7:0] POS_LENGTH     = 8'd18;
  localparam logic [7:0] POS_SATURATE   = 8'd255;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 2'd1;

  localparam logic [7:0] RST_PROTO_VERSION = 8'd1;
  localparam logic [7:0] RST_MAX_PAYLOAD   = 8'd234;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    EV_REJECT = 2'd0,
    EV_HOP    = 2'd1,
    EV_SCAN   = 2'd2
  } ev_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_XSH,
    B_MOD,
    B_FIN
  } b_state_t;

  typedef struct packed {
    logic [7:0] proto_version;
    logic [7:0] max_payload;
  } cfg_t;

  typedef struct packed {
    ev_t         ev;
    logic [7:0]  frame_channel;
    logic [31:0] sess_word;
    logic [31:0] seq_word;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/fcch_ifs.sv
interface fcch_in_if ();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, kind, data_byte, last_byte, input ready);
  modport sink   (input valid, kind, data_byte, last_byte, output ready);
endinterface

interface fcch_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [1:0] channel;

  modport source (output valid, event_res, channel, input ready);
  modport sink   (input valid, event_res, channel, output ready);
endinterface

interface fcch_cfg_if import fcch_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/fcch_queue.sv
module fcch_queue import fcch_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             ent_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? PTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = pop ? PTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/fcch_front.sv
module fcch_front import fcch_pkg::*; #(
  parameter int CHANNELS        = 3,
  parameter int HEADER_BYTES    = 19,
  parameter int TRAILER_BYTES   = 2,
  parameter int MAX_FRAME_BYTES = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  fcch_in_if.sink   in_bus,
  input  cfg_t      cfg,
  input  logic      q_full,
  output logic      q_push,
  output cmd_t      q_data
);

  localparam int L_W = 10;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        bad_r, bad_nxt;
  logic [7:0]  fch_r, fch_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] sess_r, sess_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [15:0] mcrc_r, mcrc_nxt;
  logic [7:0]  lowb_r, lowb_nxt;

  logic           acc;
  logic [7:0]     b;
  logic [7:0]     p;
  logic [L_W-1:0] p_w;
  logic [L_W-1:0] msg_len;
  logic           frame_ok;

  assign in_bus.ready = !q_full;
  assign acc          = in_bus.valid && in_bus.ready;
  assign b            = in_bus.data_byte;
  assign p            = pos_r;
  assign p_w          = L_W'(p);
  assign q_push       = acc && ((in_bus.kind == KIND_TIMEOUT) || in_bus.last_byte);

  always_comb begin
    crc_nxt  = crc_r;
    pos_nxt  = pos_r;
    bad_nxt  = bad_r;
    fch_nxt  = fch_r;
    seq_nxt  = seq_r;
    sess_nxt = sess_r;
    plen_nxt = plen_r;
    mcrc_nxt = mcrc_r;
    lowb_nxt = lowb_r;
    msg_len  = L_W'(HEADER_BYTES) + L_W'(plen_r);
    frame_ok = 1'b0;

    if (acc && in_bus.kind == KIND_BYTE) begin
      if (p >= 8'(MAX_FRAME_BYTES)) bad_nxt = 1'b1;
      if (p == POS_MAGIC0 && b != MAGIC0) bad_nxt = 1'b1;
      if (p == POS_MAGIC1 && b != MAGIC1) bad_nxt = 1'b1;
      if (p == POS_VERSION && b != cfg.proto_version) bad_nxt = 1'b1;
      if (p == POS_CHANNEL) begin
        fch_nxt = b;
        if (b >= 8'(CHANNELS)) bad_nxt = 1'b1;
      end
      if (p >= POS_SEQ_FIRST && p <= POS_SEQ_LAST) begin
        seq_nxt = {b, seq_r[31:8]};
      end
      if (p >= POS_SESS_FIRST && p <= POS_SESS_LAST) begin
        sess_nxt = {b, sess_r[31:8]};
      end
      if (p == POS_LENGTH) begin
        plen_nxt = b;
        if (b > cfg.max_payload) bad_nxt = 1'b1;
      end

      msg_len = L_W'(HEADER_BYTES) + L_W'(plen_nxt);
      if (p_w < msg_len) begin
        crc_nxt = crc_byte(crc_r, b);
      end else if (p_w == msg_len) begin
        lowb_nxt = b;
      end else if (p_w == L_W'(msg_len + 1'b1)) begin
        mcrc_nxt = {b, lowb_r};
      end

      if (pos_r != POS_SATURATE) begin
        pos_nxt = 8'(pos_r + 1'b1);
      end

      frame_ok = !bad_nxt && (p_w == L_W'(msg_len + L_W'(TRAILER_BYTES) - 1'b1))
                 && (mcrc_nxt == crc_nxt);
    end

    q_data.ev            = (in_bus.kind == KIND_TIMEOUT) ? EV_SCAN
                         : (frame_ok ? EV_HOP : EV_REJECT);
    q_data.frame_channel = fch_nxt;
    q_data.sess_word     = sess_nxt;
    q_data.seq_word      = seq_nxt;

    if (q_push) begin
      crc_nxt  = CRC_INIT;
      pos_nxt  = '0;
      bad_nxt  = 1'b0;
      fch_nxt  = '0;
      seq_nxt  = '0;
      sess_nxt = '0;
      plen_nxt = '0;
      mcrc_nxt = '0;
      lowb_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      pos_r  <= '0;
      bad_r  <= 1'b0;
      fch_r  <= '0;
      seq_r  <= '0;
      sess_r <= '0;
      plen_r <= '0;
      mcrc_r <= '0;
      lowb_r <= '0;
    end else begin
      crc_r  <= crc_nxt;
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      fch_r  <= fch_nxt;
      seq_r  <= seq_nxt;
      sess_r <= sess_nxt;
      plen_r <= plen_nxt;
      mcrc_r <= mcrc_nxt;
      lowb_r <= lowb_nxt;
    end
  end

endmodule

### hw/rtl/fcch_back.sv
module fcch_back import fcch_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_pop,
  fcch_out_if.source out_bus
);

  localparam int CH_W      = (CHANNELS > 4) ? $clog2(CHANNELS) : 2;
  localparam int DIGIT     = 4;
  localparam int MOD_STEPS = 32 / DIGIT;
  localparam int CNT_W     = $clog2(MOD_STEPS);
  localparam logic [CH_W:0]   DIVISOR  = (CH_W + 1)'(CHANNELS - 1);
  localparam logic [CH_W:0]   CH_COUNT = (CH_W + 1)'(CHANNELS);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNELS - 1);

  b_state_t state_r, state_nxt;

  logic [CH_W-1:0]  cur_r;
  logic [CH_W-1:0]  ch_r;
  logic [31:0]      sess_r;
  logic [31:0]      prod_r;
  logic [31:0]      mix_r;
  logic [CH_W-1:0]  rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  ev_t              out_ev_r;
  logic [1:0]       out_ch_r;

  logic             out_free;
  logic             is_hop;
  logic             load_out;
  logic             take_hop;
  ev_t              load_ev;
  logic [CH_W-1:0]  load_ch;
  logic [CH_W-1:0]  scan_ch;
  logic [CH_W-1:0]  hop_ch;
  logic [CH_W:0]    hop_sum;
  logic [CH_W-1:0]  rem_step;
  logic [CH_W:0]    t;
  logic [31:0]      mix_a;

  assign out_free = !out_valid_r || out_bus.ready;
  assign is_hop   = (q_data.ev == EV_HOP);
  assign scan_ch  = (cur_r == CH_LAST) ? '0 : CH_W'(cur_r + 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (q_valid && is_hop) state_nxt = B_MUL1;
      B_MUL1: state_nxt = B_MUL2;
      B_MUL2: state_nxt = B_XSH;
      B_XSH:  state_nxt = B_MOD;
      B_MOD:  if (cnt_r == CNT_W'(MOD_STEPS - 1)) state_nxt = B_FIN;
      B_FIN:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    take_hop = 1'b0;
    load_ev  = EV_REJECT;
    load_ch  = cur_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid && is_hop) begin
          q_pop    = 1'b1;
          take_hop = 1'b1;
        end else if (q_valid && out_free) begin
          q_pop    = 1'b1;
          load_out = 1'b1;
          load_ev  = q_data.ev;
          load_ch  = (q_data.ev == EV_SCAN) ? scan_ch : cur_r;
        end
      end
      B_FIN: begin
        load_out = out_free;
        load_ev  = EV_HOP;
        load_ch  = hop_ch;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // one radix-16 digit of the remainder per cycle
  always_comb begin
    t        = '0;
    rem_step = rem_r;
    for (int i = 0; i < DIGIT; i++) begin
      t = {rem_step, mix_r[31 - i]};
      if (t >= DIVISOR) t = t - DIVISOR;
      rem_step = t[CH_W-1:0];
    end
  end

  assign mix_a   = sess_r ^ prod_r;
  assign hop_sum = (CH_W + 1)'(ch_r) + (CH_W + 1)'(rem_r) + 1'b1;
  assign hop_ch  = (hop_sum >= CH_COUNT) ? CH_W'(hop_sum - CH_COUNT) : hop_sum[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        cur_r       <= load_ch;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ev_r <= load_ev;
      out_ch_r <= load_ch[1:0];
    end
    case (state_r)
      B_IDLE: begin
        if (take_hop) begin
          ch_r   <= (q_data.frame_channel < 8'(CHANNELS)) ? q_data.frame_channel[CH_W-1:0]
                                                          : '0;
          sess_r <= q_data.sess_word;
          prod_r <= q_data.seq_word;
        end
      end
      B_MUL1: prod_r <= prod_r * HASH_K1;
      B_MUL2: prod_r <= (mix_a ^ (mix_a >> 16)) * HASH_K2;
      B_XSH: begin
        mix_r <= prod_r ^ (prod_r >> 15);
        rem_r <= '0;
        cnt_r <= '0;
      end
      B_MOD: begin
        mix_r <= mix_r << DIGIT;
        rem_r <= rem_step;
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.event_res = out_ev_r;
  assign out_bus.channel   = out_ch_r;

endmodule

### hw/rtl/frame_check_channel_hopper_top.sv
// channel   dir  handshake     payload
// in_bus    in   valid/ready   kind, data_byte, last_byte
// out_bus   out  valid/ready   event_res, channel
// cfg_bus   in   valid/ready   index, data (ready always high)
//
// Frame bytes and timeouts: one transaction per cycle while the 2-entry event queue has room.
// Hop after a valid frame: the back end steps through two hash multiplies, an xor-shift and 8 remainder digits.
// Reject and scan: popped in the idle state and loaded straight into the result register.
// Reset clears frame state, current channel and config (version 1, max payload 234).
// in_bus stalls only on a full queue; out_bus stalls hold the result register.
module frame_check_channel_hopper_top import fcch_pkg::*; #(
  parameter int CHANNELS        = 3,
  parameter int HEADER_BYTES    = 19,
  parameter int TRAILER_BYTES   = 2,
  parameter int MAX_FRAME_BYTES = 255
) (
  input logic        clk,
  input logic        rst_n,
  fcch_in_if.sink    in_bus,
  fcch_out_if.source out_bus,
  fcch_cfg_if.sink   cfg_bus
);

  cfg_t cfg_r;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_wdata;
  cmd_t q_rdata;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.proto_version <= RST_PROTO_VERSION;
      cfg_r.max_payload   <= RST_MAX_PAYLOAD;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_PROTO_VERSION: cfg_r.proto_version <= cfg_bus.data;
        CFG_MAX_PAYLOAD:   cfg_r.max_payload   <= cfg_bus.data;
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  fcch_front #(
    .CHANNELS        (CHANNELS),
    .HEADER_BYTES    (HEADER_BYTES),
    .TRAILER_BYTES   (TRAILER_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  fcch_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  fcch_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("event queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("event queue underflow");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result valid right after reset");

endmodule
